FILE: hdl/frgcd_pkg.sv
// Shared types and constants for the fraction reducer.
// Holds payload structs, the controller/datapath command set and state encoding.
// No dependencies.
package frgcd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int SHIFT_BITS = $clog2(VALUE_BITS);
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t numerator_in;
        value_t denominator_in;
    } frac_in_t;

    typedef struct packed {
        value_t numerator_out;
        value_t denominator_out;
        value_t common_divisor;
    } frac_out_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_COPY_B,
        CMD_HALVE_BOTH,
        CMD_HALVE_A,
        CMD_HALVE_B,
        CMD_SUBTRACT,
        CMD_RESTORE,
        CMD_DIV_INIT,
        CMD_DIV_STEP
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_even;
        logic b_even;
        logic both_even;
        logic shift_zero;
        logic count_last;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_COMMON,
        ST_ALIGN,
        ST_REDUCE,
        ST_RESTORE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/frgcd_datapath.sv
// Datapath of the fraction reducer: binary GCD registers and two restoring dividers.
// Depends on frgcd_pkg.
module frgcd_datapath
    import frgcd_pkg::*;
(
    input  logic      clk,
    input  cmd_t      cmd,
    input  frac_in_t  operands,
    output status_t   status,
    output frac_out_t result
);

    value_t                a_reg,  a_next;
    value_t                b_reg,  b_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;
    value_t                qn_reg, qn_next;
    value_t                qd_reg, qd_next;
    value_t                rn_reg, rn_next;
    value_t                rd_reg, rd_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic                  a_gt_b;
    value_t                diff;
    logic [VALUE_BITS:0]   div_ext;
    logic [VALUE_BITS:0]   sh_n, sh_d;
    logic                  ge_n, ge_d;
    logic [VALUE_BITS:0]   sub_n, sub_d;

    assign a_gt_b = a_reg > b_reg;
    assign diff   = a_gt_b ? (a_reg - b_reg) : (b_reg - a_reg);

    // one restoring step per cycle for each quotient; divisor is the gcd in a_reg
    assign div_ext = {1'b0, a_reg};
    assign sh_n    = {rn_reg, qn_reg[VALUE_BITS-1]};
    assign sh_d    = {rd_reg, qd_reg[VALUE_BITS-1]};
    assign ge_n    = sh_n >= div_ext;
    assign ge_d    = sh_d >= div_ext;
    assign sub_n   = sh_n - div_ext;
    assign sub_d   = sh_d - div_ext;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        shift_next = shift_reg;
        qn_next    = qn_reg;
        qd_next    = qd_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        cnt_next   = cnt_reg;
        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_LOAD:
            begin
                a_next     = operands.numerator_in;
                b_next     = operands.denominator_in;
                qn_next    = operands.numerator_in;
                qd_next    = operands.denominator_in;
                shift_next = '0;
            end
            CMD_COPY_B:
            begin
                a_next = b_reg;
                b_next = '0;
            end
            CMD_HALVE_BOTH:
            begin
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                shift_next = shift_reg + SHIFT_BITS'(1);
            end
            CMD_HALVE_A:
            begin
                a_next = a_reg >> 1;
            end
            CMD_HALVE_B:
            begin
                b_next = b_reg >> 1;
            end
            CMD_SUBTRACT:
            begin
                if (a_gt_b)
                begin
                    a_next = b_reg;
                end
                b_next = diff;
            end
            CMD_RESTORE:
            begin
                a_next     = a_reg << 1;
                shift_next = shift_reg - SHIFT_BITS'(1);
            end
            CMD_DIV_INIT:
            begin
                rn_next  = '0;
                rd_next  = '0;
                cnt_next = '0;
            end
            CMD_DIV_STEP:
            begin
                rn_next  = ge_n ? sub_n[VALUE_BITS-1:0] : sh_n[VALUE_BITS-1:0];
                rd_next  = ge_d ? sub_d[VALUE_BITS-1:0] : sh_d[VALUE_BITS-1:0];
                qn_next  = {qn_reg[VALUE_BITS-2:0], ge_n};
                qd_next  = {qd_reg[VALUE_BITS-2:0], ge_d};
                cnt_next = cnt_reg + CNT_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        shift_reg <= shift_next;
        qn_reg    <= qn_next;
        qd_reg    <= qd_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        cnt_reg   <= cnt_next;
    end

    assign status.a_zero     = (a_reg == '0);
    assign status.b_zero     = (b_reg == '0);
    assign status.a_even     = ~a_reg[0];
    assign status.b_even     = ~b_reg[0];
    assign status.both_even  = ~(a_reg[0] | b_reg[0]);
    assign status.shift_zero = (shift_reg == '0);
    assign status.count_last = (cnt_reg == CNT_BITS'(VALUE_BITS - 1));

    // both inputs zero leaves a zero divisor: report all zeros
    assign result.common_divisor  = a_reg;
    assign result.numerator_out   = status.a_zero ? '0 : qn_reg;
    assign result.denominator_out = status.a_zero ? '0 : qd_reg;

endmodule

FILE: hdl/frgcd_ctrl.sv
// Controller of the fraction reducer: sequences GCD, shift restore and division.
// Depends on frgcd_pkg.
module frgcd_ctrl
    import frgcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // a zero operand skips the GCD loop entirely
                if (status.a_zero || status.b_zero)
                begin
                    state_next = ST_RESTORE;
                end
                else
                begin
                    state_next = ST_COMMON;
                end
            end
            ST_COMMON:
            begin
                if (!status.both_even)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (!status.a_even)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.b_zero)
                begin
                    state_next = ST_RESTORE;
                end
            end
            ST_RESTORE:
            begin
                if (status.shift_zero)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.count_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = CMD_NONE;
        done = 1'b0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd = CMD_LOAD;
                end
            end
            ST_PREP:
            begin
                if (status.a_zero)
                begin
                    cmd = CMD_COPY_B;
                end
            end
            ST_COMMON:
            begin
                if (status.both_even)
                begin
                    cmd = CMD_HALVE_BOTH;
                end
            end
            ST_ALIGN:
            begin
                if (status.a_even)
                begin
                    cmd = CMD_HALVE_A;
                end
            end
            ST_REDUCE:
            begin
                priority if (status.b_zero)
                begin
                    cmd = CMD_NONE;
                end
                else if (status.b_even)
                begin
                    cmd = CMD_HALVE_B;
                end
                else
                begin
                    cmd = CMD_SUBTRACT;
                end
            end
            ST_RESTORE:
            begin
                cmd = status.shift_zero ? CMD_DIV_INIT : CMD_RESTORE;
            end
            ST_DIVIDE:
            begin
                cmd = CMD_DIV_STEP;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = CMD_NONE;
            end
        endcase
    end

endmodule

FILE: hdl/fraction_reduce_by_gcd.sv
// Fraction reducer: binary GCD, then both operands divided by it.
// The GCD loop is data-dependent (one shift or subtract per cycle); it is followed by the
// one-bit-per-cycle shift restore and VALUE_BITS restoring division steps; one transaction
// at a time, the next start is taken at the earliest in the cycle after done.
// done is high for one cycle with the result; the receiver cannot stall.
// Reset (rst_n, async, active low) returns the controller to idle.
module fraction_reduce_by_gcd
    import frgcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  frac_in_t  operands,
    output logic      done,
    output frac_out_t result
);

    cmd_t    cmd;
    status_t status;

    frgcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    frgcd_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .operands (operands),
        .status   (status),
        .result   (result)
    );

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block did not return to idle after a result");

    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.common_divisor == '0) |->
        (result.numerator_out == '0 && result.denominator_out == '0))
        else $error("zero divisor with nonzero quotient");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for fraction_reduce_by_gcd: directed table, then random operands.
// Expected results come from the typed-in table rows or a Euclid-based predictor, checked in arrival order.
// Depends on frgcd_pkg and the fraction_reduce_by_gcd RTL.
module tb_top;
    import frgcd_pkg::*;

    localparam int     NUM_DIRECTED = 18;
    localparam int     NUM_RANDOM   = 1750;
    localparam int     DRAIN_CYCLES = 8 * VALUE_BITS;
    localparam value_t VALUE_MAX    = {VALUE_BITS{1'b1}};

    typedef struct {
        value_t    num;
        value_t    den;
        logic      has_want;
        frac_out_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    frac_in_t  operands;
    logic      done;
    frac_out_t result;

    // Expectation handed along with each transaction (typed-in rows only)
    logic      want_given;
    frac_out_t want_value;

    frac_out_t reduced_q[$];
    int        mismatch_count = 0;

    fraction_reduce_by_gcd dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic frac_out_t reduce_fraction(value_t num, value_t den);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] rem;
        frac_out_t   r;
        a = 64'(num);
        b = 64'(den);
        r = '0;
        if (a == 0 && b == 0)
            return r;
        while (b != 0)
        begin
            rem = a % b;
            a = b;
            b = rem;
        end
        r.numerator_out   = value_t'(64'(num) / a);
        r.denominator_out = value_t'(64'(den) / a);
        r.common_divisor  = value_t'(a);
        return r;
    endfunction

    function automatic frac_out_t make_result(value_t n, value_t d, value_t g);
        frac_out_t r;
        r.numerator_out   = n;
        r.denominator_out = d;
        r.common_divisor  = g;
        return r;
    endfunction

    function automatic dir_row_t dir_row(int idx);
        dir_row_t r;
        r.has_want = 1'b1;
        r.want     = '0;
        case (idx)
            0:  begin r.num = 1;          r.den = 1;          r.want = make_result(1, 1, 1); end
            1:  begin r.num = VALUE_MAX;  r.den = VALUE_MAX;
                      r.want = make_result(1, 1, VALUE_MAX); end
            2:  begin r.num = VALUE_MAX;  r.den = 1;
                      r.want = make_result(VALUE_MAX, 1, 1); end
            3:  begin r.num = 1;          r.den = VALUE_MAX;
                      r.want = make_result(1, VALUE_MAX, 1); end
            // zero numerator: divisor is the denominator
            4:  begin r.num = 0;          r.den = 5;          r.want = make_result(0, 1, 5); end
            // zero denominator: divisor is the numerator
            5:  begin r.num = 7;          r.den = 0;          r.want = make_result(1, 0, 7); end
            // both zero: all-zero result
            6:  begin r.num = 0;          r.den = 0;          r.want = make_result(0, 0, 0); end
            7:  begin r.num = 0;          r.den = VALUE_MAX;
                      r.want = make_result(0, 1, VALUE_MAX); end
            8:  begin r.num = 1 << 30;    r.den = 1 << 30;
                      r.want = make_result(1, 1, 1 << 30); end
            9:  begin r.num = 1 << 30;    r.den = 1 << 29;
                      r.want = make_result(2, 1, 1 << 29); end
            10: begin r.num = 12;         r.den = 18;         r.want = make_result(2, 3, 6); end
            11: begin r.num = VALUE_MAX;  r.den = 1 << 30;
                      r.want = make_result(VALUE_MAX, 1 << 30, 1); end
            12: begin r.num = 1000000007; r.den = 2000000014;
                      r.want = make_result(1, 2, 1000000007); end
            13: begin r.num = VALUE_MAX - 1; r.den = VALUE_MAX >> 1;
                      r.want = make_result(2, 1, VALUE_MAX >> 1); end
            14: begin r.num = 123456789;  r.den = 987654321;  r.has_want = 1'b0; end
            15: begin r.num = 3 << 28;    r.den = 1 << 30;    r.has_want = 1'b0; end
            16: begin r.num = 31'h2aaaaaaa; r.den = 31'h55555555; r.has_want = 1'b0; end
            default:
                begin r.num = 6;          r.den = 35;         r.has_want = 1'b0; end
        endcase
        return r;
    endfunction

    function automatic value_t rand_value();
        value_t v;
        v = value_t'($urandom);
        if (v == 0)
            v = 1;
        return v;
    endfunction

    function automatic frac_in_t rand_operands();
        frac_in_t    v;
        int unsigned g;
        int unsigned k;
        case ($urandom_range(0, 5))
            0:
                begin
                    v.numerator_in   = rand_value();
                    v.denominator_in = rand_value();
                end
            1:
                begin
                    // large shared factor
                    g = $urandom_range(1, 65535);
                    v.numerator_in   = value_t'(g * $urandom_range(1, VALUE_MAX / g));
                    v.denominator_in = value_t'(g * $urandom_range(1, VALUE_MAX / g));
                end
            2:
                begin
                    // common factor 2**k, k from 0 to VALUE_BITS-1
                    k = $urandom_range(0, VALUE_BITS - 1);
                    v.numerator_in   = value_t'($urandom_range(1, VALUE_MAX >> k) << k);
                    v.denominator_in = value_t'($urandom_range(1, VALUE_MAX >> k) << k);
                end
            3:
                begin
                    v.numerator_in   = rand_value();
                    v.denominator_in = v.numerator_in;
                end
            4:
                begin
                    v.numerator_in   = value_t'($urandom_range(1, 255));
                    v.denominator_in = value_t'($urandom_range(1, 255));
                end
            default:
                begin
                    case ($urandom_range(0, 2))
                        0:       v.numerator_in = VALUE_MAX;
                        1:       v.numerator_in = 1;
                        default: v.numerator_in = value_t'(1) << $urandom_range(0, VALUE_BITS - 1);
                    endcase
                    v.denominator_in = rand_value();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        v.denominator_in = v.numerator_in;
                        v.numerator_in   = rand_value();
                    end
                end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, frac_out_t want, frac_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): want n=%0d d=%0d g=%0d, got n=%0d d=%0d g=%0d",
                     what, want.numerator_out, want.denominator_out, want.common_divisor,
                     got.numerator_out, got.denominator_out, got.common_divisor);
    endtask

    // Check before push; done and an accepted start never fall on the same edge
    always @(posedge clk)
    begin
        frac_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (reduced_q.size() == 0)
                    report_mismatch("no transaction pending", '0, result);
                else
                begin
                    want = reduced_q.pop_front();
                    if (result.numerator_out !== want.numerator_out)
                        report_mismatch("numerator_out", want, result);
                    else if (result.denominator_out !== want.denominator_out)
                        report_mismatch("denominator_out", want, result);
                    else if (result.common_divisor !== want.common_divisor)
                        report_mismatch("common_divisor", want, result);
                end
            end
            if (start && busy === 1'b0)
            begin
                if (want_given)
                    reduced_q.push_back(want_value);
                else
                    reduced_q.push_back(reduce_fraction(operands.numerator_in,
                                                        operands.denominator_in));
            end
        end
    end

    task automatic send_item(frac_in_t v, logic given, frac_out_t want, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        operands   <= v;
        want_given <= given;
        want_value <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (reduced_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        dir_row_t r;
        frac_in_t v;
        logic     no_gaps;
        int       gap;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        operands   <= '0;
        want_given <= 1'b0;
        want_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            r = dir_row(i);
            v.numerator_in   = r.num;
            v.denominator_in = r.den;
            send_item(v, r.has_want, r.want, $urandom_range(0, 15));
        end

        no_gaps = 1'b0;
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (i == NUM_RANDOM / 3 || i == 2 * NUM_RANDOM / 3)
                wait_idle();
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            send_item(rand_operands(), 1'b0, '0, gap);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && reduced_q.size() == 0)
            $display("[fraction_reduce_by_gcd] OK");
        else
            $display("[fraction_reduce_by_gcd] ERROR");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("[fraction_reduce_by_gcd] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/frgcd_pkg.sv
hdl/frgcd_datapath.sv
hdl/frgcd_ctrl.sv
hdl/fraction_reduce_by_gcd.sv
dv/tb_top.sv
